[src/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted max-priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VAL_W         = 31;
  localparam int CMD_W         = 2;
  localparam int CNT_OUT_W     = 5;
  localparam int DEFAULT_DEPTH = 16;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  // Broadcast from the controller to every cell in the row.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [VAL_W-1:0] value;
  } spq_ctl_t;

endpackage

[src/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a value, shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic             clk,
  input  spq_ctl_t         ctl,
  input  logic             occ,
  input  logic             left_ge,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] val,
  output logic             ge
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // This slot holds a value that stays ahead of the new one.
  assign ge  = occ && (val_r >= ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.push) begin
      if (!ge) begin
        val_nxt = left_ge ? ctl.value : left_val;
      end
    end else if (ctl.pop) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[src/sorted_max_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_max_priority_queue
// Bounded max-priority queue kept in descending order in a row of cells.
// ----------------------------------------------------------------------------
// Commands are taken on any cycle with start high; busy is always low, so one
// item enters every clock. Each command gives exactly one result, shown with
// out_valid high for one cycle, the cycle right after the command is taken;
// the receiver cannot stall, so sample it then. Each command is handled by
// the row of cells: every slot compares its value to the pushed one in
// parallel and shifts toward its neighbor in the same cycle. A push inserts
// behind equal values, a pop drops the largest (no-op when empty), a peek and
// the unused code act as a read. A push to a full queue is dropped and flags
// out_overflow on its result. The result reports the queue after the command:
// the largest value (0 when empty), the count and an empty flag.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [VAL_W-1:0]     in_value,
  output logic                 out_valid,
  output logic [VAL_W-1:0]     out_top_value,
  output logic [CNT_OUT_W-1:0] out_entry_count,
  output logic                 out_is_empty,
  output logic                 out_overflow
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             full;
  logic             empty;
  logic             is_push;
  logic             is_pop;
  spq_ctl_t         ctl;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_overflow_r;

  logic [VAL_W-1:0] cell_val [QUEUE_DEPTH];
  logic             cell_ge  [QUEUE_DEPTH];

  // Never stall the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  // Decode the command; the unused code reads like a peek.
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    unique case (in_command)
      CMD_PUSH: is_push = 1'b1;
      CMD_POP:  is_pop  = 1'b1;
      CMD_PEEK: ;
      default:  ;
    endcase
  end

  // Drop a push to a full queue and a pop from an empty one.
  assign ctl.push  = accept && is_push && !full;
  assign ctl.pop   = accept && is_pop && !empty;
  assign ctl.value = in_value;

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Row of cells: slot 0 holds the largest value. Each slot sees its left
  // neighbor's value and compare result for an insert, and its right
  // neighbor's value for a pop.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             occ;
    logic             left_ge;
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_ge  = 1'b1;
      assign left_val = in_value;
    end else begin : g_body
      assign left_ge  = cell_ge[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_ge   (left_ge),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i]),
      .ge        (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      out_overflow_r <= 1'b0;
    end else begin
      count_r        <= count_nxt;
      out_valid_r    <= accept;
      out_overflow_r <= accept && is_push && full;
    end
  end

  // Report the queue as it stands after the command.
  assign out_valid       = out_valid_r;
  assign out_top_value   = empty ? '0 : cell_val[0];
  assign out_entry_count = CNT_OUT_W'(count_r);
  assign out_is_empty    = empty;
  assign out_overflow    = out_overflow_r;

  // Every taken command yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result missing after accepted command");

  // A dropped push leaves the queue full.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |-> (out_valid && full))
    else $error("overflow flagged on a queue that is not full");

  // A successful pop lowers the count by exactly one.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not decrement the count");

  // The count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

endmodule
